### rtl/core/paoor_pkg.sv
package paoor_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_RELINQ = 2'd1,
    CMD_READ   = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_DENIED  = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_RELINQ_DEFAULT = 3'd0,
    REG_HI_LIM         = 3'd1,
    REG_LO_LIM         = 3'd2,
    REG_DEADBAND       = 3'd3,
    REG_DLY_TICKS      = 3'd4,
    REG_LIM_EN         = 3'd5,
    REG_EVT_EN         = 3'd6
  } reg_idx_t;

  // alarm state codes
  localparam logic [1:0] EV_NORMAL = 2'd0;
  localparam logic [1:0] EV_HIGH   = 2'd1;
  localparam logic [1:0] EV_LOW    = 2'd2;
  localparam logic [1:0] EV_STRAY  = 2'd3;

  localparam int LIM_LOW_BIT      = 0;
  localparam int LIM_HIGH_BIT     = 1;
  localparam int EV_OFFNORMAL_BIT = 0;
  localparam int EV_TONORMAL_BIT  = 2;

  localparam int PIDX_W    = 4;   // enough for 16 priorities
  localparam int LVL_INT_W = 7;   // whole levels 0..100

  localparam logic signed [15:0] LEVEL_MAX_Q88 = 16'sd25600;
  localparam logic [7:0]         RESERVED_PRIO = 8'd6;

  typedef struct packed {
    logic signed [15:0] relinq_dflt;
    logic signed [15:0] hi_lim;
    logic signed [15:0] lo_lim;
    logic signed [15:0] deadband;
    logic [15:0]        dly_ticks;
    logic [1:0]         lim_en;
    logic [2:0]         evt_en;
  } cfg_regs_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic                 known;
    logic                 apply;
    status_t              status;
    logic [7:0]           inst;
    logic [PIDX_W-1:0]    pidx;
    logic [LVL_INT_W-1:0] lvl_int;
  } cmd_word_t;

  typedef struct packed {
    status_t            status;
    logic signed [15:0] pres_val;
    logic [1:0]         ev_state;
    logic [1:0]         from_state;
    logic               event_changed;
    logic signed [15:0] exceeded_limit;
  } result_t;

endpackage

### rtl/core/paoor_front.sv
module paoor_front #(
  parameter int INSTANCES       = 4,
  parameter int PRIORITY_LEVELS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            in_command,
  input  logic [7:0]            in_instance_req,
  input  logic [7:0]            in_priority_req,
  input  logic signed [15:0]    in_level,
  input  logic                  cq_pop,
  output logic                  cq_empty,
  output paoor_pkg::cmd_word_t  cq_head
);
  import paoor_pkg::*;

  cmd_word_t  word;
  cmd_word_t  q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       known, prio_ok, lvl_ok, reserved, wr_ok;
  logic       push_ok, pop_ok;

  // classify
  always_comb begin
    known    = {1'b0, in_instance_req} < 9'(INSTANCES);
    prio_ok  = (in_priority_req >= 8'd1) && (in_priority_req <= 8'(PRIORITY_LEVELS));
    lvl_ok   = (in_level >= 16'sd0) && (in_level <= LEVEL_MAX_Q88);
    reserved = in_priority_req == RESERVED_PRIO;
    wr_ok    = prio_ok && !reserved && lvl_ok;

    word         = '0;
    word.cmd     = cmd_t'(in_command);
    word.known   = known;
    word.inst    = in_instance_req;
    word.pidx    = PIDX_W'(in_priority_req - 8'd1);
    word.lvl_int = in_level[14:8];
    word.status  = ST_OK;
    word.apply   = 1'b0;
    case (word.cmd)
      CMD_WRITE: begin
        word.apply = wr_ok;
        if (wr_ok)
          word.status = ST_OK;
        else if (reserved)
          word.status = ST_DENIED;
        else
          word.status = ST_RANGE;
      end
      CMD_RELINQ: begin
        word.apply  = prio_ok;
        word.status = prio_ok ? ST_OK : ST_RANGE;
      end
      default: begin
        word.apply  = 1'b0;
        word.status = ST_OK;
      end
    endcase
    if (!known) begin
      word.apply  = 1'b0;
      word.status = ST_UNKNOWN;
    end
  end

  // two-word command queue
  assign full     = cnt_r == 2'd2;
  assign cq_empty = cnt_r == 2'd0;
  assign push_ok  = push && !full;
  assign pop_ok   = cq_pop && !cq_empty;
  assign cq_head  = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_ok)
        wp_r <= !wp_r;
      if (pop_ok)
        rp_r <= !rp_r;
      if (push_ok && !pop_ok)
        cnt_r <= cnt_r + 2'd1;
      else if (!push_ok && pop_ok)
        cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok)
      q_r[wp_r] <= word;
  end

endmodule

### rtl/core/paoor_back.sv
module paoor_back #(
  parameter int INSTANCES       = 4,
  parameter int PRIORITY_LEVELS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  paoor_pkg::cfg_regs_t  cfg,
  input  logic                  dly_reload,
  input  logic                  cq_empty,
  input  paoor_pkg::cmd_word_t  cq_head,
  output logic                  cq_pop,
  input  logic                  res_full,
  output logic                  res_push,
  output paoor_pkg::result_t    res_word
);
  import paoor_pkg::*;

  localparam int IW     = (INSTANCES > 1) ? $clog2(INSTANCES) : 1;
  localparam int PW     = $clog2(PRIORITY_LEVELS);
  localparam int LVL_AW = IW + PW;

  typedef struct packed {
    logic [PRIORITY_LEVELS-1:0] mask;   // set = entry holds a level
    logic [1:0]                 alarm;
    logic [15:0]                delay;
  } row_t;

  typedef enum logic [1:0] {B_IDLE, B_UPD, B_RD, B_EVAL} state_t;

  state_t state_r;

  row_t                 row_mem [INSTANCES];
  logic [LVL_INT_W-1:0] lvl_mem [2**LVL_AW];

  logic [INSTANCES-1:0] row_vld_r, stale_r;

  cmd_word_t            cw_r;
  row_t                 row_rd_r;
  logic                 vld_rd_r, stale_rd_r;
  logic [LVL_INT_W-1:0] lvl_rd_r;
  logic [PRIORITY_LEVELS-1:0] mask_r;
  logic [1:0]           alarm_r;
  logic [15:0]          delay_r;
  logic [PW-1:0]        first_r;
  logic                 any_r;

  logic                 start;
  logic [IW-1:0]        cur_idx, head_idx;
  logic [PW-1:0]        pidx;
  logic [PRIORITY_LEVELS-1:0] mask_new;
  logic [PW-1:0]        first;
  logic                 any;
  logic                 lvl_wr, row_wr;

  logic signed [15:0]   pv;
  logic signed [17:0]   pv_x, hi_x, lo_x, hi_db, lo_db;
  logic                 is_tick, cond, hi_en, lo_en, off_en, norm_en;
  logic [1:0]           target, new_alarm;
  logic [15:0]          new_delay;
  logic                 changed;
  logic signed [15:0]   exceeded;

  assign start    = (state_r == B_IDLE) && !cq_empty && !res_full;
  assign cq_pop   = start;
  assign head_idx = cq_head.inst[IW-1:0];
  assign cur_idx  = cw_r.inst[IW-1:0];
  assign pidx     = cw_r.pidx[PW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      unique case (state_r)
        B_IDLE:  if (start) state_r <= B_UPD;
        B_UPD:   state_r <= B_RD;
        B_RD:    state_r <= B_EVAL;
        B_EVAL:  state_r <= B_IDLE;
        default: state_r <= B_IDLE;
      endcase
    end
  end

  // row fetch
  always_ff @(posedge clk) begin
    if (start) begin
      cw_r       <= cq_head;
      row_rd_r   <= row_mem[head_idx];
      vld_rd_r   <= row_vld_r[head_idx];
      stale_rd_r <= stale_r[head_idx];
    end
  end

  // apply the command to the null mask, find the first non-null entry
  always_comb begin
    mask_new = vld_rd_r ? row_rd_r.mask : '0;
    if (cw_r.apply)
      mask_new[pidx] = cw_r.cmd == CMD_WRITE;
    first = '0;
    any   = 1'b0;
    for (int i = PRIORITY_LEVELS - 1; i >= 0; i--) begin
      if (mask_new[i]) begin
        first = PW'(i);
        any   = 1'b1;
      end
    end
  end

  assign lvl_wr = (state_r == B_UPD) && cw_r.apply && (cw_r.cmd == CMD_WRITE);

  always_ff @(posedge clk) begin
    if (state_r == B_UPD) begin
      mask_r  <= mask_new;
      alarm_r <= vld_rd_r ? row_rd_r.alarm : EV_NORMAL;
      delay_r <= stale_rd_r ? cfg.dly_ticks : row_rd_r.delay;
      first_r <= first;
      any_r   <= any;
    end
  end

  always_ff @(posedge clk) begin
    if (lvl_wr)
      lvl_mem[{cur_idx, pidx}] <= cw_r.lvl_int;
    if (state_r == B_RD)
      lvl_rd_r <= lvl_mem[{cur_idx, first_r}];
  end

  // alarm evaluation
  always_comb begin
    pv      = any_r ? {1'b0, lvl_rd_r, 8'h00} : cfg.relinq_dflt;
    pv_x    = 18'(pv);
    hi_x    = 18'(cfg.hi_lim);
    lo_x    = 18'(cfg.lo_lim);
    hi_db   = hi_x - 18'(cfg.deadband);
    lo_db   = lo_x + 18'(cfg.deadband);
    hi_en   = cfg.lim_en[LIM_HIGH_BIT];
    lo_en   = cfg.lim_en[LIM_LOW_BIT];
    off_en  = cfg.evt_en[EV_OFFNORMAL_BIT];
    norm_en = cfg.evt_en[EV_TONORMAL_BIT];
    is_tick = (cw_r.cmd == CMD_TICK) && (cfg.lim_en != 2'd0);

    cond   = 1'b0;
    target = EV_NORMAL;
    case (alarm_r)
      EV_NORMAL: begin
        if ((pv_x > hi_x) && hi_en && off_en) begin
          cond   = 1'b1;
          target = EV_HIGH;
        end else if ((pv_x < lo_x) && lo_en && off_en) begin
          cond   = 1'b1;
          target = EV_LOW;
        end
      end
      EV_HIGH: cond = (pv_x < hi_db) && hi_en && norm_en;
      EV_LOW:  cond = (pv_x > lo_db) && lo_en && norm_en;
      default: cond = 1'b0;
    endcase

    new_alarm = alarm_r;
    new_delay = delay_r;
    // a stray fourth code is left alone, countdown included
    if (is_tick && (alarm_r != EV_STRAY)) begin
      if (!cond)
        new_delay = cfg.dly_ticks;
      else if (delay_r == 16'd0)
        new_alarm = target;
      else
        new_delay = delay_r - 16'd1;
    end

    changed  = new_alarm != alarm_r;
    exceeded = '0;
    if (changed) begin
      if ((new_alarm == EV_HIGH) || ((new_alarm == EV_NORMAL) && (alarm_r == EV_HIGH)))
        exceeded = cfg.hi_lim;
      else
        exceeded = cfg.lo_lim;
    end

    res_word = '0;
    if (!cw_r.known) begin
      res_word.status = ST_UNKNOWN;
    end else begin
      res_word.status         = cw_r.status;
      res_word.pres_val       = pv;
      res_word.ev_state       = new_alarm;
      res_word.from_state     = alarm_r;
      res_word.event_changed  = changed;
      res_word.exceeded_limit = exceeded;
    end
  end

  assign res_push = state_r == B_EVAL;
  assign row_wr   = (state_r == B_EVAL) && cw_r.known;

  always_ff @(posedge clk) begin
    if (row_wr)
      row_mem[cur_idx] <= '{mask: mask_r, alarm: new_alarm, delay: new_delay};
  end

  // row_vld: row holds real mask/alarm; stale: delay reads as the reload value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      stale_r   <= '1;
    end else begin
      if (dly_reload)
        stale_r <= '1;
      if (row_wr) begin
        row_vld_r[cur_idx] <= 1'b1;
        stale_r[cur_idx]   <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/paoor_resq.sv
module paoor_resq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_push,
  input  paoor_pkg::result_t  res_word,
  output logic                res_full,
  input  logic                pop,
  output logic                empty,
  output paoor_pkg::result_t  head
);
  import paoor_pkg::*;

  result_t    q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push_ok, pop_ok;

  assign res_full = cnt_r == 2'd2;
  assign empty    = cnt_r == 2'd0;
  assign push_ok  = res_push && !res_full;
  assign pop_ok   = pop && !empty;
  assign head     = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_ok)
        wp_r <= !wp_r;
      if (pop_ok)
        rp_r <= !rp_r;
      if (push_ok && !pop_ok)
        cnt_r <= cnt_r + 2'd1;
      else if (!push_ok && pop_ok)
        cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok)
      q_r[wp_r] <= res_word;
  end

endmodule

### rtl/core/priority_array_out_of_range_alarm.sv
// channel   ports                                        handshake
// -------   -------------------------------------------  ------------------------
// input     in_command in_instance_req in_priority_req   push & !full
//           in_level
// result    out_status out_pres_val out_ev_state         pop & !empty
//           out_from_state out_event_changed out_exceeded_limit
// config    cfg_index cfg_wdata                          cfg_we, no wait
//
// Each word passes through the back-end sequencer in order: instance row read, mask update
// with priority encode, level memory read, alarm evaluation and write-back; the sequencer
// takes the next word only after write-back. The front end takes a word every cycle into a
// 2-deep command queue while that queue is not full; results wait in a 2-deep result queue,
// and the back end holds off while that queue is full. Reset is synchronous; per-instance
// valid and stale bits stand in for clearing the tables, so words are accepted right after reset.
module priority_array_out_of_range_alarm #(
  parameter int INSTANCES       = 4,
  parameter int PRIORITY_LEVELS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         in_command,
  input  logic [7:0]         in_instance_req,
  input  logic [7:0]         in_priority_req,
  input  logic signed [15:0] in_level,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         out_status,
  output logic signed [15:0] out_pres_val,
  output logic [1:0]         out_ev_state,
  output logic [1:0]         out_from_state,
  output logic               out_event_changed,
  output logic signed [15:0] out_exceeded_limit,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);
  import paoor_pkg::*;

  cfg_regs_t cfg_r, cfg_nxt;
  logic      dly_reload;
  logic      cq_pop, cq_empty;
  cmd_word_t cq_head;
  logic      res_push, res_full;
  result_t   res_word, head;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_RELINQ_DEFAULT: cfg_nxt.relinq_dflt = cfg_wdata;
        REG_HI_LIM:         cfg_nxt.hi_lim      = cfg_wdata;
        REG_LO_LIM:         cfg_nxt.lo_lim      = cfg_wdata;
        REG_DEADBAND:       cfg_nxt.deadband    = cfg_wdata;
        REG_DLY_TICKS:      cfg_nxt.dly_ticks   = cfg_wdata;
        REG_LIM_EN:         cfg_nxt.lim_en      = cfg_wdata[1:0];
        REG_EVT_EN:         cfg_nxt.evt_en      = cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      cfg_r <= '0;
    else
      cfg_r <= cfg_nxt;
  end

  // writing the delay register reloads every countdown
  assign dly_reload = cfg_we && (cfg_index == REG_DLY_TICKS);

  paoor_front #(
    .INSTANCES       (INSTANCES),
    .PRIORITY_LEVELS (PRIORITY_LEVELS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_command      (in_command),
    .in_instance_req (in_instance_req),
    .in_priority_req (in_priority_req),
    .in_level        (in_level),
    .cq_pop          (cq_pop),
    .cq_empty        (cq_empty),
    .cq_head         (cq_head)
  );

  paoor_back #(
    .INSTANCES       (INSTANCES),
    .PRIORITY_LEVELS (PRIORITY_LEVELS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .dly_reload (dly_reload),
    .cq_empty   (cq_empty),
    .cq_head    (cq_head),
    .cq_pop     (cq_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_word   (res_word)
  );

  paoor_resq u_resq (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .res_word (res_word),
    .res_full (res_full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  assign out_status         = head.status;
  assign out_pres_val       = head.pres_val;
  assign out_ev_state       = head.ev_state;
  assign out_from_state     = head.from_state;
  assign out_event_changed  = head.event_changed;
  assign out_exceeded_limit = head.exceeded_limit;

`ifndef SYNTHESIS
  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full result queue");

  a_change_moves_state: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_event_changed) |-> (out_ev_state != out_from_state))
    else $error("event_changed without a state change");

  a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_status == ST_UNKNOWN)) |->
      ((out_pres_val == 16'sd0) && !out_event_changed &&
       (out_exceeded_limit == 16'sd0)))
    else $error("unknown instance result carries data");
`endif

endmodule

### dv/paoor_checker.sv
module paoor_checker #(
  parameter int INSTANCES       = 4,
  parameter int PRIORITY_LEVELS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic               full,
  input  logic [1:0]         in_command,
  input  logic [7:0]         in_instance_req,
  input  logic [7:0]         in_priority_req,
  input  logic signed [15:0] in_level,
  input  logic               empty,
  input  logic               pop,
  input  logic [1:0]         out_status,
  input  logic signed [15:0] out_pres_val,
  input  logic [1:0]         out_ev_state,
  input  logic [1:0]         out_from_state,
  input  logic               out_event_changed,
  input  logic signed [15:0] out_exceeded_limit,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  output int                 mismatches,
  output int                 outstanding,
  output int                 transitions
);
  import paoor_pkg::*;

  localparam logic [7:0] LEVEL_NULL = 8'hff;
  localparam int REPORT_CAP = 100;

  logic [7:0]         level_tab [INSTANCES][PRIORITY_LEVELS];
  logic [1:0]         alarm_st [INSTANCES];
  logic [15:0]        delay_left [INSTANCES];
  logic signed [15:0] relinq_dflt;
  logic signed [15:0] hi_limit;
  logic signed [15:0] lo_limit;
  logic signed [15:0] dead_band;
  logic [15:0]        delay_reload;
  logic [1:0]         lim_en;
  logic [2:0]         evt_en;

  result_t pending_results [$];

  function automatic int present_of(int inst);
    for (int p = 0; p < PRIORITY_LEVELS; p++)
      if (level_tab[inst][p] != LEVEL_NULL) return int'(level_tab[inst][p]) * 256;
    return int'(relinq_dflt);
  endfunction

  // updates the object state for one word and returns the word the block owes
  function automatic result_t apply_command(cmd_t cmd, logic [7:0] inst, logic [7:0] prio,
                                            logic signed [15:0] lvl);
    result_t    r;
    logic       prio_ok;
    logic       cond;
    logic       known_state;
    logic [1:0] prev_state;
    logic [1:0] target;
    int         pv;
    int         hi;
    int         lo;
    int         db;
    r = '0;
    r.status = ST_OK;
    if (inst >= INSTANCES) begin
      r.status = ST_UNKNOWN;
      return r;
    end
    prev_state = alarm_st[inst];
    prio_ok = prio >= 1 && prio <= PRIORITY_LEVELS;
    hi = hi_limit;
    lo = lo_limit;
    db = dead_band;
    case (cmd)
      CMD_WRITE: begin
        if (prio_ok && prio != RESERVED_PRIO && lvl >= 0 && lvl <= LEVEL_MAX_Q88)
          level_tab[inst][prio - 1] = lvl[15:8];
        else if (prio == RESERVED_PRIO)
          r.status = ST_DENIED;
        else
          r.status = ST_RANGE;
      end
      CMD_RELINQ: begin
        if (prio_ok) level_tab[inst][prio - 1] = LEVEL_NULL;
        else r.status = ST_RANGE;
      end
      CMD_TICK: begin
        if (lim_en != 0) begin
          pv = present_of(inst);
          cond = 1'b0;
          target = prev_state;
          known_state = 1'b1;
          case (prev_state)
            EV_NORMAL: begin
              if (pv > hi && lim_en[LIM_HIGH_BIT] && evt_en[EV_OFFNORMAL_BIT]) begin
                cond = 1'b1;
                target = EV_HIGH;
              end else if (pv < lo && lim_en[LIM_LOW_BIT] && evt_en[EV_OFFNORMAL_BIT]) begin
                cond = 1'b1;
                target = EV_LOW;
              end
            end
            EV_HIGH: begin
              cond = pv < hi - db && lim_en[LIM_HIGH_BIT] && evt_en[EV_TONORMAL_BIT];
              target = EV_NORMAL;
            end
            EV_LOW: begin
              cond = pv > lo + db && lim_en[LIM_LOW_BIT] && evt_en[EV_TONORMAL_BIT];
              target = EV_NORMAL;
            end
            default: known_state = 1'b0;
          endcase
          if (known_state) begin
            if (!cond) delay_left[inst] = delay_reload;
            else if (delay_left[inst] == 0) alarm_st[inst] = target;
            else delay_left[inst] = delay_left[inst] - 1;
          end
          if (alarm_st[inst] != prev_state) begin
            r.event_changed = 1'b1;
            // high limit for entering or leaving high, low limit otherwise
            r.exceeded_limit = (alarm_st[inst] == EV_HIGH || prev_state == EV_HIGH) ?
                               hi_limit : lo_limit;
          end
        end
      end
      default: ;
    endcase
    r.pres_val = 16'(present_of(inst));
    r.ev_state = alarm_st[inst];
    r.from_state = prev_state;
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      if (mismatches < REPORT_CAP)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      for (int i = 0; i < INSTANCES; i++) begin
        for (int p = 0; p < PRIORITY_LEVELS; p++) level_tab[i][p] = LEVEL_NULL;
        alarm_st[i] = EV_NORMAL;
        delay_left[i] = '0;
      end
      relinq_dflt = '0;
      hi_limit = '0;
      lo_limit = '0;
      dead_band = '0;
      delay_reload = '0;
      lim_en = '0;
      evt_en = '0;
      pending_results.delete();
      mismatches = 0;
      transitions = 0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_RELINQ_DEFAULT: relinq_dflt = cfg_wdata;
          REG_HI_LIM:         hi_limit = cfg_wdata;
          REG_LO_LIM:         lo_limit = cfg_wdata;
          REG_DEADBAND:       dead_band = cfg_wdata;
          REG_DLY_TICKS: begin
            // also reloads every countdown
            delay_reload = cfg_wdata;
            for (int i = 0; i < INSTANCES; i++) delay_left[i] = cfg_wdata;
          end
          REG_LIM_EN:         lim_en = cfg_wdata[1:0];
          REG_EVT_EN:         evt_en = cfg_wdata[2:0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          if (mismatches < REPORT_CAP)
            $display("%0t: result word with nothing expected, status %h value %h",
                     $time, out_status, out_pres_val);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          compare_field("status", 16'(want.status), 16'(out_status));
          compare_field("pres_val", want.pres_val, out_pres_val);
          compare_field("ev_state", 16'(want.ev_state), 16'(out_ev_state));
          compare_field("from_state", 16'(want.from_state), 16'(out_from_state));
          compare_field("event_changed", 16'(want.event_changed), 16'(out_event_changed));
          compare_field("exceeded_limit", want.exceeded_limit, out_exceeded_limit);
          if (out_event_changed) transitions++;
        end
      end
      if (push && !full)
        pending_results.push_back(apply_command(cmd_t'(in_command), in_instance_req,
                                                in_priority_req, in_level));
    end
    outstanding = pending_results.size();
  end

endmodule

### dv/testbench.sv
module testbench;
  import paoor_pkg::*;

  localparam int INSTANCES       = 4;
  localparam int PRIORITY_LEVELS = 16;
  localparam int PHASES          = 12;
  localparam int WORDS_PER_PHASE = 156;
  localparam int QUIET_LIMIT     = 3000;
  localparam int DRAIN_CYCLES    = 8;

  typedef enum logic [1:0] {PACE_FREE, PACE_COIN, PACE_EVERY4, PACE_RUNS} pace_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic [1:0]         in_command = CMD_READ;
  logic [7:0]         in_instance_req = '0;
  logic [7:0]         in_priority_req = '0;
  logic signed [15:0] in_level = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [1:0]         out_status;
  logic signed [15:0] out_pres_val;
  logic [1:0]         out_ev_state;
  logic [1:0]         out_from_state;
  logic               out_event_changed;
  logic signed [15:0] out_exceeded_limit;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_wdata = '0;

  int mismatches;
  int outstanding;
  int transitions;

  int    sent = 0;
  int    received = 0;
  int    burst_left = 0;
  int    quiet = 0;
  int    pace_cnt = 0;
  pace_t pace_mode = PACE_FREE;

  logic [15:0] set_relinq;
  logic [15:0] set_high;
  logic [15:0] set_low;
  logic [15:0] set_deadband;
  logic [15:0] set_delay;
  logic [1:0]  set_lim_en;
  logic [2:0]  set_evt_en;

  always #4 clk = ~clk;

  priority_array_out_of_range_alarm #(
    .INSTANCES(INSTANCES),
    .PRIORITY_LEVELS(PRIORITY_LEVELS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_command(in_command),
    .in_instance_req(in_instance_req),
    .in_priority_req(in_priority_req),
    .in_level(in_level),
    .empty(empty),
    .pop(pop),
    .out_status(out_status),
    .out_pres_val(out_pres_val),
    .out_ev_state(out_ev_state),
    .out_from_state(out_from_state),
    .out_event_changed(out_event_changed),
    .out_exceeded_limit(out_exceeded_limit),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  paoor_checker #(
    .INSTANCES(INSTANCES),
    .PRIORITY_LEVELS(PRIORITY_LEVELS)
  ) checker_i (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_command(in_command),
    .in_instance_req(in_instance_req),
    .in_priority_req(in_priority_req),
    .in_level(in_level),
    .empty(empty),
    .pop(pop),
    .out_status(out_status),
    .out_pres_val(out_pres_val),
    .out_ev_state(out_ev_state),
    .out_from_state(out_from_state),
    .out_event_changed(out_event_changed),
    .out_exceeded_limit(out_exceeded_limit),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .mismatches(mismatches),
    .outstanding(outstanding),
    .transitions(transitions)
  );

  // result side: stall pattern switches whenever the low byte of pace_cnt wraps to zero
  always @(posedge clk) begin
    pace_cnt <= pace_cnt + 1;
    if (pace_cnt[7:0] == 8'd0) pace_mode <= pace_t'($urandom_range(0, 3));
    if (pop && !empty) received <= received + 1;
    case (pace_mode)
      PACE_FREE:   pop <= 1'b1;
      PACE_COIN:   pop <= 1'($urandom_range(0, 1));
      PACE_EVERY4: pop <= (pace_cnt[1:0] == 2'd0);
      default:     if ($urandom_range(0, 7) == 0) pop <= !pop;
    endcase
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || cfg_we || !rst_n) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet == QUIET_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
      $display("[priority_array_out_of_range_alarm] ERROR");
      $finish;
    end
  end

  task automatic send_word(input cmd_t cmd, input logic [7:0] inst, input logic [7:0] prio,
                           input logic [15:0] lvl);
    int gap;
    in_command <= cmd;
    in_instance_req <= inst;
    in_priority_req <= prio;
    in_level <= lvl;
    push <= 1'b1;
    do @(posedge clk); while (full);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) :
                   $urandom_range(1, 24);
    end
  endtask

  // wait until every result is back and the back end has drained
  task automatic settle();
    push <= 1'b0;
    while (received != sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs();
    cfg_we <= 1'b1;
    cfg_index <= REG_RELINQ_DEFAULT;
    cfg_wdata <= set_relinq;
    @(posedge clk);
    cfg_index <= REG_HI_LIM;
    cfg_wdata <= set_high;
    @(posedge clk);
    cfg_index <= REG_LO_LIM;
    cfg_wdata <= set_low;
    @(posedge clk);
    cfg_index <= REG_DEADBAND;
    cfg_wdata <= set_deadband;
    @(posedge clk);
    cfg_index <= REG_DLY_TICKS;
    cfg_wdata <= set_delay;
    @(posedge clk);
    cfg_index <= REG_LIM_EN;
    cfg_wdata <= 16'(set_lim_en);
    @(posedge clk);
    cfg_index <= REG_EVT_EN;
    cfg_wdata <= 16'(set_evt_en);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic choose_settings(input int ph);
    case (ph)
      0: begin
        set_relinq = 16'h0500; set_high = 16'h3200; set_low = 16'h1400;
        set_deadband = 16'h0200; set_delay = 16'd0; set_lim_en = 2'd3; set_evt_en = 3'd5;
      end
      1: begin
        set_relinq = 16'h8000; set_high = 16'h7fff; set_low = 16'h8000;
        set_deadband = 16'h7fff; set_delay = 16'hffff; set_lim_en = 2'd3; set_evt_en = 3'd7;
      end
      2: begin
        // most negative deadband, with the limits swapped to the 16-bit extremes
        set_relinq = 16'h7fff; set_high = 16'h8000; set_low = 16'h7fff;
        set_deadband = 16'h8000; set_delay = 16'd1; set_lim_en = 2'd3; set_evt_en = 3'd5;
      end
      3: begin
        set_relinq = 16'h0000; set_high = 16'h4000; set_low = 16'h2000;
        set_deadband = 16'h0100; set_delay = 16'd2; set_lim_en = 2'd1; set_evt_en = 3'd1;
      end
      4: begin
        set_relinq = 16'h6400; set_high = 16'h2800; set_low = 16'h0a00;
        set_deadband = 16'h0000; set_delay = 16'd0; set_lim_en = 2'd2; set_evt_en = 3'd4;
      end
      default: begin
        set_relinq = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 25600));
        set_high = 16'($urandom_range(0, 26000));
        set_low = 16'($urandom_range(0, set_high));
        set_deadband = 16'($urandom_range(0, 2048));
        if ($urandom_range(0, 4) == 0) begin
          set_high = 16'($urandom);
          set_low = 16'($urandom);
          set_deadband = 16'($urandom);
        end
        set_delay = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
        set_lim_en = ($urandom_range(0, 4) < 3) ? 2'd3 : 2'($urandom_range(0, 3));
        set_evt_en = ($urandom_range(0, 1) == 0) ? 3'd5 : 3'($urandom_range(0, 7));
      end
    endcase
  endtask

  task automatic send_random_word();
    int         sel;
    cmd_t       cmd;
    logic [7:0] inst;
    logic [7:0] prio;
    logic [15:0] lvl;
    sel = $urandom_range(0, 99);
    if (sel < 30) cmd = CMD_WRITE;
    else if (sel < 50) cmd = CMD_RELINQ;
    else if (sel < 62) cmd = CMD_READ;
    else cmd = CMD_TICK;
    inst = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, INSTANCES - 1));
    prio = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(1, PRIORITY_LEVELS));
    sel = $urandom_range(0, 9);
    if (sel < 6) lvl = 16'($urandom_range(0, 25600));
    else if (sel < 8) lvl = {8'($urandom_range(0, 100)), 8'h00};
    else lvl = 16'($urandom);
    send_word(cmd, inst, prio, lvl);
  endtask

  task automatic run_directed();
    // reset settings: everything null, alarms disabled
    send_word(CMD_READ,   8'd0, 8'd1,  16'h0000);
    send_word(CMD_TICK,   8'd0, 8'd1,  16'h0000);
    send_word(CMD_WRITE,  8'd0, 8'd1,  16'h0000);
    send_word(CMD_WRITE,  8'd0, 8'd16, 16'h6400);
    send_word(CMD_WRITE,  8'd0, 8'd2,  16'h6401);
    send_word(CMD_WRITE,  8'd0, 8'd3,  16'hffff);
    send_word(CMD_WRITE,  8'd0, RESERVED_PRIO, 16'h0100);
    send_word(CMD_WRITE,  8'd0, RESERVED_PRIO, 16'h8000);
    send_word(CMD_WRITE,  8'd0, 8'd0,  16'h0100);
    send_word(CMD_WRITE,  8'd0, 8'd17, 16'h0100);
    send_word(CMD_WRITE,  8'd0, 8'd255, 16'h7fff);
    send_word(CMD_WRITE,  8'd1, 8'd1,  16'h32ff);
    send_word(CMD_RELINQ, 8'd0, RESERVED_PRIO, 16'h0000);
    send_word(CMD_RELINQ, 8'd0, 8'd1,  16'h0000);
    send_word(CMD_RELINQ, 8'd0, 8'd0,  16'h0000);
    send_word(CMD_RELINQ, 8'd0, 8'd17, 16'h0000);
    send_word(CMD_WRITE,  8'd4, 8'd1,  16'h0100);
    send_word(CMD_READ,   8'd255, 8'd1, 16'h0000);
    send_word(CMD_TICK,   8'd128, 8'd1, 16'h0000);
    send_word(CMD_READ,   8'd3, 8'd1,  16'h0000);
    settle();
    set_relinq = 16'h0500; set_high = 16'h3200; set_low = 16'h0a00;
    set_deadband = 16'h0100; set_delay = 16'd1; set_lim_en = 2'd3; set_evt_en = 3'd5;
    write_regs();
    // walk instance 1 from normal to low and back to normal
    send_word(CMD_WRITE,  8'd1, 8'd4,  16'h3c80);
    send_word(CMD_TICK,   8'd1, 8'd0,  16'h0000);
    send_word(CMD_TICK,   8'd1, 8'd0,  16'h0000);
    send_word(CMD_RELINQ, 8'd1, 8'd4,  16'h0000);
    send_word(CMD_RELINQ, 8'd1, 8'd1,  16'h0000);
    send_word(CMD_TICK,   8'd1, 8'd0,  16'h0000);
    send_word(CMD_TICK,   8'd1, 8'd0,  16'h0000);
    send_word(CMD_WRITE,  8'd1, 8'd16, 16'h6400);
    send_word(CMD_TICK,   8'd1, 8'd0,  16'h0000);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      choose_settings(ph);
      write_regs();
      repeat (WORDS_PER_PHASE) send_random_word();
    end
    settle();
    $display("%0d words checked under %0d register settings; %0d alarm transitions seen",
             sent, PHASES + 1, transitions);
    if (mismatches == 0 && outstanding == 0)
      $display("[priority_array_out_of_range_alarm] OK");
    else
      $display("[priority_array_out_of_range_alarm] ERROR");
    $finish;
  end

endmodule

### files.f
rtl/core/paoor_pkg.sv
rtl/core/paoor_front.sv
rtl/core/paoor_back.sv
rtl/core/paoor_resq.sv
rtl/core/priority_array_out_of_range_alarm.sv
dv/paoor_checker.sv
dv/testbench.sv
